### rtl/perspective_warp_source_address_core_macros.svh
// assertion macros for the perspective warp source address core
// used by rtl/perspective_warp_source_address_core.sv, no other dependencies
`ifndef PERSPECTIVE_WARP_SOURCE_ADDRESS_CORE_MACROS_SVH
`define PERSPECTIVE_WARP_SOURCE_ADDRESS_CORE_MACROS_SVH
`ifndef SYNTH
`define PWSA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pwsa assertion failed");
`define PWSA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pwsa assertion failed");
`else
`define PWSA_ASSERT_IMP(lbl, ante, cons)
`define PWSA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/pwsa_pkg.sv
// shared constants and register codes for the perspective warp source address core
// no dependencies
package pwsa_pkg;
	localparam int COEF_W = 48;
	localparam int PLANE_W = 32;
	localparam int PROD_W = 82;
	localparam int CFG_IDX_W = 3;
	localparam int DEF_COEF_FRAC_BITS = 32;
	localparam int DEF_DIM_BITS = 16;
	localparam int DEF_WIDTH = 640;
	localparam int DEF_HEIGHT = 480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_XX = 3'd0,
		REG_COEF_XY = 3'd1,
		REG_COEF_YX = 3'd2,
		REG_COEF_YY = 3'd3,
		REG_PERSP_X = 3'd4,
		REG_PERSP_Y = 3'd5,
		REG_SRC_WIDTH = 3'd6,
		REG_SRC_HEIGHT = 3'd7
	} cfg_reg_t;
endpackage

### rtl/perspective_warp_source_address_core.sv
// channel  | dir | payload
// s_axis   | in  | tdata: plane_u [31:0], plane_v [63:32]
// m_axis   | out | tdata: src_col, src_row (DIM_BITS each, zero padded); tuser: inside_res
// cfg      | in  | cfg_index selects register, cfg_data holds value (low bits for dims)
// one item per cycle while the output register is empty or taken; stages in order: multiply, sum,
// sign, scale products, scale sum, compare, then one quotient bit per divider stage
// the whole pipeline advances together whenever the output register is empty or taken
// reset clears valid bits and loads the default registers; no clearing pass
// depends on pwsa_pkg, pwsa_divider and the assertion macro header
`include "perspective_warp_source_address_core_macros.svh"
module perspective_warp_source_address_core #(
	parameter int COEF_FRAC_BITS = pwsa_pkg::DEF_COEF_FRAC_BITS,
	parameter int DIM_BITS = pwsa_pkg::DEF_DIM_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  logic [2*pwsa_pkg::PLANE_W-1:0]           s_axis_tdata,  // plane_u, plane_v
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	output logic [((2*DIM_BITS+7)/8)*8-1:0]          m_axis_tdata,  // src_col, src_row
	output logic                                     m_axis_tuser,  // inside_res
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [pwsa_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [pwsa_pkg::COEF_W-1:0]              cfg_data
);
	localparam int CW = pwsa_pkg::COEF_W;
	localparam int PW = pwsa_pkg::PLANE_W;
	localparam int XW = pwsa_pkg::PROD_W;
	localparam int SW = XW + DIM_BITS + 1;
	localparam int NW = XW + DIM_BITS;
	localparam int OW = ((2*DIM_BITS+7)/8)*8;
	localparam int MC = 28;
	localparam logic signed [XW-1:0] ONE = XW'(1) << (COEF_FRAC_BITS + 16);
	localparam logic [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC_BITS;

	logic signed [CW-1:0]     coef_q [6];
	logic [DIM_BITS-1:0]      width_q, height_q;
	logic                     en;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [CW-1:0]     ph_s1 [6];
	logic signed [PW+32:0]    pl_s1 [6];
	logic signed [XW-1:0]     nx_s2, ny_s2, w_s2;
	logic signed [XW-1:0]     nx_s3, ny_s3, w_s3;
	logic                     wz_s3, wz_s4, wz_s5;
	logic signed [XW-1:0]     nx_s4, ny_s4, w_s4;
	logic [MC+DIM_BITS-1:0]   wwp_s4 [3];
	logic [MC+DIM_BITS-1:0]   whp_s4 [3];
	logic signed [XW-1:0]     nx_s5, ny_s5, w_s5;
	logic signed [SW-1:0]     ww_s5, wh_s5;
	logic                     in_s6;
	logic [NW-1:0]            na_s6, nb_s6;
	logic [XW-1:0]            d_s6;

	logic signed [XW-1:0]     prod [6];
	logic signed [SW-1:0]     nx_x, ny_x, ry;
	logic                     in_range;
	logic                     flag;
	logic [DIM_BITS-1:0]      qa, qb;

	assign cfg_ready = 1'b1;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= COEF_ONE;
			coef_q[1] <= '0;
			coef_q[2] <= '0;
			coef_q[3] <= COEF_ONE;
			coef_q[4] <= '0;
			coef_q[5] <= '0;
			width_q <= DIM_BITS'(pwsa_pkg::DEF_WIDTH);
			height_q <= DIM_BITS'(pwsa_pkg::DEF_HEIGHT);
		end else if (cfg_valid) begin
			unique case (pwsa_pkg::cfg_reg_t'(cfg_index))
				pwsa_pkg::REG_COEF_XX: coef_q[0] <= cfg_data;
				pwsa_pkg::REG_COEF_XY: coef_q[1] <= cfg_data;
				pwsa_pkg::REG_COEF_YX: coef_q[2] <= cfg_data;
				pwsa_pkg::REG_COEF_YY: coef_q[3] <= cfg_data;
				pwsa_pkg::REG_PERSP_X: coef_q[4] <= cfg_data;
				pwsa_pkg::REG_PERSP_Y: coef_q[5] <= cfg_data;
				pwsa_pkg::REG_SRC_WIDTH: width_q <= cfg_data[DIM_BITS-1:0];
				pwsa_pkg::REG_SRC_HEIGHT: height_q <= cfg_data[DIM_BITS-1:0];
				default: width_q <= width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 1: split partial products, upper 16 and lower 32 coefficient bits
	for (genvar i = 0; i < 6; i++) begin : g_mul
		logic signed [PW-1:0] x;
		logic signed [15:0]   c_hi;
		logic signed [32:0]   c_lo;
		assign x = (i % 2 == 0) ? $signed(s_axis_tdata[PW-1:0])
			: $signed(s_axis_tdata[2*PW-1:PW]);
		assign c_hi = coef_q[i][CW-1:32];
		assign c_lo = $signed({1'b0, coef_q[i][31:0]});
		always_ff @(posedge clk) begin
			if (en) begin
				ph_s1[i] <= CW'(c_hi * x);
				pl_s1[i] <= (PW+33)'(c_lo * x);
			end
		end
		assign prod[i] = (XW'(ph_s1[i]) <<< 32) + XW'(pl_s1[i]);
	end

	// stages 2 to 5: sums, sign normalize, chunked bound products, bound sums
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2 <= prod[0] + prod[1];
			ny_s2 <= prod[2] + prod[3];
			w_s2 <= prod[4] + prod[5] + ONE;
			nx_s3 <= w_s2[XW-1] ? -nx_s2 : nx_s2;
			ny_s3 <= w_s2[XW-1] ? -ny_s2 : ny_s2;
			w_s3 <= w_s2[XW-1] ? -w_s2 : w_s2;
			wz_s3 <= (w_s2 == '0);
			nx_s4 <= nx_s3;
			ny_s4 <= ny_s3;
			w_s4 <= w_s3;
			wz_s4 <= wz_s3;
			wwp_s4[0] <= (MC+DIM_BITS)'(w_s3[MC-1:0] * width_q);
			wwp_s4[1] <= (MC+DIM_BITS)'(w_s3[2*MC-1:MC] * width_q);
			wwp_s4[2] <= (MC+DIM_BITS)'(w_s3[XW-1:2*MC] * width_q);
			whp_s4[0] <= (MC+DIM_BITS)'(w_s3[MC-1:0] * height_q);
			whp_s4[1] <= (MC+DIM_BITS)'(w_s3[2*MC-1:MC] * height_q);
			whp_s4[2] <= (MC+DIM_BITS)'(w_s3[XW-1:2*MC] * height_q);
			nx_s5 <= nx_s4;
			ny_s5 <= ny_s4;
			w_s5 <= w_s4;
			wz_s5 <= wz_s4;
			ww_s5 <= SW'(wwp_s4[0]) + (SW'(wwp_s4[1]) << MC) + (SW'(wwp_s4[2]) << (2*MC));
			wh_s5 <= SW'(whp_s4[0]) + (SW'(whp_s4[1]) << MC) + (SW'(whp_s4[2]) << (2*MC));
		end
	end

	// stage 6: range check and dividends
	assign nx_x = SW'(nx_s5);
	assign ny_x = SW'(ny_s5);
	assign ry = wh_s5 - SW'(w_s5) - ny_x;
	assign in_range = !wz_s5 && (width_q != '0) && (height_q != '0)
		&& (-w_s5 < nx_s5) && (nx_x < ww_s5)
		&& (-w_s5 < ny_s5) && (ny_x < wh_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			in_s6 <= in_range;
			d_s6 <= w_s5;
			na_s6 <= (in_range && !nx_s5[XW-1]) ? NW'(unsigned'(nx_s5)) : '0;
			nb_s6 <= (in_range && !ry[SW-1]) ? ry[NW-1:0] : '0;
		end
	end

	pwsa_divider #(
		.DIM_BITS(DIM_BITS),
		.DEN_W(XW),
		.NUM_W(NW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s6),
		.in_flag(in_s6),
		.in_na(na_s6),
		.in_nb(nb_s6),
		.in_d(d_s6),
		.out_valid(m_axis_tvalid),
		.out_flag(flag),
		.out_qa(qa),
		.out_qb(qb)
	);

	assign m_axis_tuser = flag;
	assign m_axis_tdata = flag ? OW'({qb, qa}) : '0;

	`PWSA_ASSERT_IMP(a_zero_outside, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
	`PWSA_ASSERT_IMP(a_col_range, m_axis_tvalid && m_axis_tuser, qa < width_q)
	`PWSA_ASSERT_IMP(a_row_range, m_axis_tvalid && m_axis_tuser, qb < height_q)
	`PWSA_ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, v_s1)
endmodule

### rtl/pwsa_divider.sv
// pipelined restoring divider, one quotient bit per stage, two dividends on one divisor
// uses no package
module pwsa_divider #(
	parameter int DIM_BITS = 16,
	parameter int DEN_W = 82,
	parameter int NUM_W = 98
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic                in_flag,
	input  logic [NUM_W-1:0]    in_na,
	input  logic [NUM_W-1:0]    in_nb,
	input  logic [DEN_W-1:0]    in_d,
	output logic                out_valid,
	output logic                out_flag,
	output logic [DIM_BITS-1:0] out_qa,
	output logic [DIM_BITS-1:0] out_qb
);
	logic                v_s    [DIM_BITS];
	logic                f_s    [DIM_BITS];
	logic [NUM_W-1:0]    ra_s   [DIM_BITS];
	logic [NUM_W-1:0]    rb_s   [DIM_BITS];
	logic [DEN_W-1:0]    d_s    [DIM_BITS];
	logic [DIM_BITS-1:0] qa_s   [DIM_BITS];
	logic [DIM_BITS-1:0] qb_s   [DIM_BITS];

	for (genvar k = 0; k < DIM_BITS; k++) begin : g_step
		localparam int B = DIM_BITS - 1 - k;
		logic                vi, fi;
		logic [NUM_W-1:0]    na, nb, trial;
		logic [DEN_W-1:0]    di;
		logic [DIM_BITS-1:0] qa, qb;
		logic                ge_a, ge_b;

		if (k == 0) begin : g_first
			assign vi = in_valid;
			assign fi = in_flag;
			assign na = in_na;
			assign nb = in_nb;
			assign di = in_d;
			assign qa = '0;
			assign qb = '0;
		end else begin : g_next
			assign vi = v_s[k-1];
			assign fi = f_s[k-1];
			assign na = ra_s[k-1];
			assign nb = rb_s[k-1];
			assign di = d_s[k-1];
			assign qa = qa_s[k-1];
			assign qb = qb_s[k-1];
		end

		assign trial = NUM_W'(di) << B;
		assign ge_a = na >= trial;
		assign ge_b = nb >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				f_s[k] <= fi;
				d_s[k] <= di;
				ra_s[k] <= ge_a ? na - trial : na;
				rb_s[k] <= ge_b ? nb - trial : nb;
				qa_s[k] <= qa | (DIM_BITS'(ge_a) << B);
				qb_s[k] <= qb | (DIM_BITS'(ge_b) << B);
			end
		end
	end

	assign out_valid = v_s[DIM_BITS-1];
	assign out_flag = f_s[DIM_BITS-1];
	assign out_qa = qa_s[DIM_BITS-1];
	assign out_qb = qb_s[DIM_BITS-1];
endmodule
